### rtl/hsl_pkg.sv
// Shared types and constants for the HSL hue-rotation pixel block.
// Used by hsl_div, hsl_fade and hsl_hue_rotate_pixel; depends on nothing.
`timescale 1ns / 1ps

package hsl_pkg;

    // Input beat: pixel or end-of-frame tick.
    typedef struct packed {
        logic       mode;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    // Result beat.
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [3:0] fade_level;
    } t_pix_out;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HUE_STEP  = 2'd0;
    localparam logic [1:0] CFG_FADE_PEAK = 2'd1;

    localparam logic [15:0] HUE_STEP_RST  = 16'd655;
    localparam logic [3:0]  FADE_PEAK_RST = 4'd3;

    // One third and two thirds of a turn in Q0.16.
    localparam logic [15:0] THIRD_TURN     = 16'd21845;
    localparam logic [15:0] TWO_THIRD_TURN = 16'd43691;

    // Long-division pipeline: operand width and quotient bits (one per stage).
    localparam int DIV_W     = 11;
    localparam int DIV_STEPS = 17;

    // Segment of the tone ramp for one channel.
    typedef enum logic [1:0] {
        RGN_RISE   = 2'd0,
        RGN_TOP    = 2'd1,
        RGN_FALL   = 2'd2,
        RGN_BOTTOM = 2'd3
    } t_rgn;

    // Control that travels beside the data through the pipeline.
    typedef struct packed {
        logic       vld;
        logic       tick;
        logic       zero;
        logic [3:0] lvl;
    } t_side;

    // Fade level now and after an accepted tick.
    typedef struct packed {
        logic [3:0] now;
        logic [3:0] next;
    } t_fade_lvl;

    // Whole part of a tenths count (exact for counts below 160).
    function automatic logic [3:0] tenths_to_level(input logic [7:0] tenths);
        logic [15:0] m;
        m = {8'd0, tenths} * 16'd205;
        return m[14:11];
    endfunction

endpackage

### rtl/hsl_div.sv
// Pipelined restoring divider: floor(num * 65536 / den), one quotient bit per stage.
// Depends on hsl_pkg for the operand width and the stage count.
`timescale 1ns / 1ps

module hsl_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [hsl_pkg::DIV_W-1:0]   i_num,
    input  logic [hsl_pkg::DIV_W-1:0]   i_den,
    output logic [hsl_pkg::DIV_STEPS-1:0] o_quot
);
    import hsl_pkg::*;

    logic [DIV_W-1:0]     r_rem  [DIV_STEPS];
    logic [DIV_W-1:0]     r_den  [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quot [DIV_STEPS];
    logic [DIV_W-1:0]     n_rem  [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_quot [DIV_STEPS];

    // Each stage compares the shifted remainder with the divisor and subtracts.
    always_comb begin
        logic [DIV_W:0]   x;
        logic [DIV_W-1:0] dk;
        logic             ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                x  = {1'b0, i_num};
                dk = i_den;
            end else begin
                x  = {r_rem[k-1], 1'b0};
                dk = r_den[k-1];
            end
            ge = (x >= {1'b0, dk});
            if (ge) begin
                n_rem[k] = DIV_W'(x - {1'b0, dk});
            end else begin
                n_rem[k] = x[DIV_W-1:0];
            end
            if (k == 0) begin
                n_quot[k] = {{(DIV_STEPS-1){1'b0}}, ge};
            end else begin
                n_quot[k] = {r_quot[k-1][DIV_STEPS-2:0], ge};
            end
        end
    end

    // Stage registers advance together with the rest of the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_quot[k] <= n_quot[k];
                r_den[k]  <= (k == 0) ? i_den : r_den[k-1];
            end
        end
    end

    assign o_quot = r_quot[DIV_STEPS-1];

endmodule

### rtl/hsl_fade.sv
// Triangle fade counter kept in tenths, advanced by accepted tick beats.
// Depends on hsl_pkg for the level struct and the tenths-to-level function.
`timescale 1ns / 1ps

module hsl_fade (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic [3:0]         i_peak,
    output hsl_pkg::t_fade_lvl o_lvl
);
    import hsl_pkg::*;

    logic [7:0] r_tenths, n_tenths;
    logic       r_falling, n_falling;
    logic [7:0] w_peak10;

    assign w_peak10 = 8'({i_peak, 3'b000}) + 8'({i_peak, 1'b0});

    // Next count: saturating step up or down, turning at the peak and at zero.
    always_comb begin
        n_tenths  = r_tenths;
        n_falling = r_falling;
        if (!r_falling) begin
            if (r_tenths != 8'd255) begin
                n_tenths = r_tenths + 8'd1;
            end
            if (n_tenths >= w_peak10) begin
                n_falling = 1'b1;
            end
        end else begin
            if (r_tenths != 8'd0) begin
                n_tenths = r_tenths - 8'd1;
            end
            if (n_tenths == 8'd0) begin
                n_falling = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tenths  <= 8'd0;
            r_falling <= 1'b0;
        end else if (i_tick) begin
            r_tenths  <= n_tenths;
            r_falling <= n_falling;
        end
    end

    assign o_lvl.now  = tenths_to_level(r_tenths);
    assign o_lvl.next = tenths_to_level(n_tenths);

endmodule

### rtl/hsl_hue_rotate_pixel.sv
// HSL hue-rotation pixel block: RGB to HSL, hue shift, HSL back to RGB, fade counter.
// Depends on hsl_pkg, hsl_div (saturation and hue lanes) and hsl_fade.
//
// Usage:
//   Input channel i_pix_valid / o_pix_ready carries one t_pix_in beat: a pixel
//   (mode 0) or an end-of-frame tick (mode 1). Output channel o_res_valid /
//   i_res_ready returns one t_pix_out beat for every input beat, in order.
//   Configuration writes use i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; the port is always ready and should be used while idle.
//   The result beat passes 23 register stages: the 17-stage long division
//   (one quotient bit per stage) plus six other stages.
//   Throughput is one beat per clock while the receiver takes results.
//   Tick beats update the fade counter at acceptance, so later pixels see the
//   new level. When the receiver stalls, the whole pipeline holds and the
//   input side drops ready; nothing is lost or repeated.
//   Synchronous reset empties the pipeline, clears the fade counter and
//   loads hue_step = 655 and fade_peak = 3.
`timescale 1ns / 1ps

module hsl_hue_rotate_pixel (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pix_valid,
    output logic              o_pix_ready,
    input  hsl_pkg::t_pix_in  i_pix,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output hsl_pkg::t_pix_out o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import hsl_pkg::*;

    logic w_en;
    logic w_acc;

    logic [15:0] r_hue_step;
    logic [3:0]  r_fade_peak;
    t_fade_lvl   w_lvl;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_step  <= HUE_STEP_RST;
            r_fade_peak <= FADE_PEAK_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HUE_STEP:  r_hue_step  <= i_cfg_data;
                CFG_FADE_PEAK: r_fade_peak <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign w_en        = !o_res_valid || i_res_ready;
    assign o_pix_ready = w_en;
    assign w_acc       = i_pix_valid && w_en;

    hsl_fade u_fade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (w_acc && i_pix.mode),
        .i_peak  (r_fade_peak),
        .o_lvl   (w_lvl)
    );

    // Stage A: register the beat with the level it must report.
    t_side      r_a_side;
    logic [7:0] r_a_r, r_a_g, r_a_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side.vld <= 1'b0;
        end else if (w_en) begin
            r_a_side.vld <= i_pix_valid;
        end
        if (w_en) begin
            r_a_side.tick <= i_pix.mode;
            r_a_side.zero <= 1'b0;
            r_a_side.lvl  <= i_pix.mode ? w_lvl.next : w_lvl.now;
            r_a_r         <= i_pix.in_red;
            r_a_g         <= i_pix.in_green;
            r_a_b         <= i_pix.in_blue;
        end
    end

    // Stage B: maximum, minimum, sum and the two dividends and divisors.
    logic [7:0]       w_mx, w_mn, w_d;
    logic [8:0]       w_sum, w_den_s;
    logic [DIV_W-1:0] w_d11, w_d6, w_num_h;

    always_comb begin
        w_mx = (r_a_r > r_a_g) ? r_a_r : r_a_g;
        if (r_a_b > w_mx) begin
            w_mx = r_a_b;
        end
        w_mn = (r_a_r < r_a_g) ? r_a_r : r_a_g;
        if (r_a_b < w_mn) begin
            w_mn = r_a_b;
        end
        w_d     = w_mx - w_mn;
        w_sum   = {1'b0, w_mx} + {1'b0, w_mn};
        w_den_s = (w_sum > 9'd255) ? (9'd510 - w_sum) : w_sum;
        w_d11   = {3'b000, w_d};
        w_d6    = (w_d11 << 2) + (w_d11 << 1);
        // Hexcone sector: red, then green, then blue wins a tie for maximum.
        if (w_mx == r_a_r) begin
            if (r_a_g >= r_a_b) begin
                w_num_h = {3'b000, r_a_g - r_a_b};
            end else begin
                w_num_h = w_d6 - {3'b000, r_a_b - r_a_g};
            end
        end else if (w_mx == r_a_g) begin
            w_num_h = (w_d11 << 1) + {3'b000, r_a_b} - {3'b000, r_a_r};
        end else begin
            w_num_h = (w_d11 << 2) + {3'b000, r_a_r} - {3'b000, r_a_g};
        end
    end

    t_side            r_b_side;
    logic [8:0]       r_b_sum;
    logic [DIV_W-1:0] r_b_num_s, r_b_den_s, r_b_num_h, r_b_den_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_side.vld <= 1'b0;
        end else if (w_en) begin
            r_b_side.vld <= r_a_side.vld;
        end
        if (w_en) begin
            r_b_side.tick <= r_a_side.tick;
            r_b_side.lvl  <= r_a_side.lvl;
            r_b_side.zero <= (w_d == 8'd0);
            r_b_sum       <= w_sum;
            r_b_num_s     <= w_d11;
            r_b_den_s     <= {2'b00, w_den_s};
            r_b_num_h     <= w_num_h;
            r_b_den_h     <= w_d6;
        end
    end

    // Lightness by the reciprocal of 255: l = 128 * sum + floor(128 * sum / 255).
    logic [15:0] w_y;
    logic [16:0] w_lf, w_lq;
    logic [15:0] w_l_b;

    always_comb begin
        w_y   = {r_b_sum, 7'd0};
        w_lf  = {1'b0, w_y} + {9'd0, w_y[15:8]} + 17'd1;
        w_lq  = {1'b0, w_y} + {8'd0, w_lf[16:8]};
        w_l_b = w_lq[16] ? 16'hFFFF : w_lq[15:0];
    end

    // Division lanes for saturation and hue.
    logic [DIV_STEPS-1:0] w_quot_s, w_quot_h;

    hsl_div u_div_s (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (r_b_num_s), .i_den (r_b_den_s), .o_quot (w_quot_s)
    );

    hsl_div u_div_h (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (r_b_num_h), .i_den (r_b_den_h), .o_quot (w_quot_h)
    );

    // Side control and lightness delayed to match the division lanes.
    t_side       r_sd    [DIV_STEPS];
    logic [15:0] r_l_dly [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_sd[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_sd[k].vld <= (k == 0) ? r_b_side.vld : r_sd[k-1].vld;
            end
        end
        if (w_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_sd[k].tick <= (k == 0) ? r_b_side.tick : r_sd[k-1].tick;
                r_sd[k].zero <= (k == 0) ? r_b_side.zero : r_sd[k-1].zero;
                r_sd[k].lvl  <= (k == 0) ? r_b_side.lvl  : r_sd[k-1].lvl;
                r_l_dly[k]   <= (k == 0) ? w_l_b : r_l_dly[k-1];
            end
        end
    end

    // Stage C: saturate quotients, rotate hue, form l * s.
    t_side       w_c_in;
    logic [15:0] w_l, w_s, w_h;
    logic [31:0] w_ls;

    assign w_c_in = r_sd[DIV_STEPS-1];

    always_comb begin
        w_l = r_l_dly[DIV_STEPS-1];
        if (w_c_in.zero) begin
            w_s = 16'd0;
            w_h = 16'd0;
        end else begin
            w_s = w_quot_s[16] ? 16'hFFFF : w_quot_s[15:0];
            w_h = w_quot_h[16] ? 16'hFFFF : w_quot_h[15:0];
        end
        w_ls = w_l * w_s;
    end

    t_side       r_c_side;
    logic [15:0] r_c_l, r_c_s, r_c_h, r_c_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side.vld <= 1'b0;
        end else if (w_en) begin
            r_c_side.vld <= w_c_in.vld;
        end
        if (w_en) begin
            r_c_side.tick <= w_c_in.tick;
            r_c_side.zero <= w_c_in.zero;
            r_c_side.lvl  <= w_c_in.lvl;
            r_c_l         <= w_l;
            r_c_s         <= w_s;
            r_c_h         <= w_h + r_hue_step;
            r_c_m         <= w_ls[31:16];
        end
    end

    // Stage D: q and p, plus ramp segment and factor for red and blue.
    logic [17:0] w_qx, w_twol, w_pd;
    logic [15:0] w_q, w_p;
    logic [15:0] w_t   [2];
    logic [18:0] w_t6  [2];
    t_rgn        w_rgn [2];
    logic [16:0] w_f   [2];

    always_comb begin
        if (r_c_l[15]) begin
            w_qx = {2'b00, r_c_l} + {2'b00, r_c_s} - {2'b00, r_c_m};
        end else begin
            w_qx = {2'b00, r_c_l} + {2'b00, r_c_m};
        end
        w_q    = (w_qx > 18'd65535) ? 16'hFFFF : w_qx[15:0];
        w_twol = {1'b0, r_c_l, 1'b0};
        w_pd   = w_twol - {2'b00, w_q};
        if (w_twol < {2'b00, w_q}) begin
            w_p = 16'd0;
        end else if (w_pd > {2'b00, w_q}) begin
            w_p = w_q;
        end else begin
            w_p = w_pd[15:0];
        end
        w_t[0] = r_c_h + THIRD_TURN;
        w_t[1] = r_c_h + TWO_THIRD_TURN;
        for (int c = 0; c < 2; c++) begin
            w_t6[c] = ({3'b000, w_t[c]} << 2) + ({3'b000, w_t[c]} << 1);
            if (w_t6[c] < 19'd65536) begin
                w_rgn[c] = RGN_RISE;
            end else if (!w_t[c][15]) begin
                w_rgn[c] = RGN_TOP;
            end else if (!w_t6[c][18]) begin
                w_rgn[c] = RGN_FALL;
            end else begin
                w_rgn[c] = RGN_BOTTOM;
            end
            if (w_rgn[c] == RGN_RISE) begin
                w_f[c] = w_t6[c][16:0];
            end else begin
                w_f[c] = 17'(19'd262144 - w_t6[c]);
            end
        end
    end

    t_side       r_d_side;
    logic [15:0] r_d_q, r_d_p;
    t_rgn        r_d_rgn [2];
    logic [16:0] r_d_f   [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side.vld <= 1'b0;
        end else if (w_en) begin
            r_d_side.vld <= r_c_side.vld;
        end
        if (w_en) begin
            r_d_side.tick <= r_c_side.tick;
            r_d_side.zero <= r_c_side.zero;
            r_d_side.lvl  <= r_c_side.lvl;
            r_d_q         <= w_q;
            r_d_p         <= w_p;
            for (int c = 0; c < 2; c++) begin
                r_d_rgn[c] <= w_rgn[c];
                r_d_f[c]   <= w_f[c];
            end
        end
    end

    // Stage E: tone value per channel from the ramp.
    logic [15:0] w_diff;
    logic [32:0] w_pr [2];
    logic [17:0] w_v  [2];
    logic [15:0] w_tone [2];

    always_comb begin
        w_diff = r_d_q - r_d_p;
        for (int c = 0; c < 2; c++) begin
            w_pr[c] = {17'd0, w_diff} * {16'd0, r_d_f[c]};
            w_v[c]  = {2'b00, r_d_p} + {1'b0, w_pr[c][32:16]};
            unique case (r_d_rgn[c])
                RGN_RISE, RGN_FALL: begin
                    w_tone[c] = (w_v[c] > 18'd65535) ? 16'hFFFF : w_v[c][15:0];
                end
                RGN_TOP:    w_tone[c] = r_d_q;
                RGN_BOTTOM: w_tone[c] = r_d_p;
            endcase
        end
    end

    t_side       r_e_side;
    logic [15:0] r_e_v [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side.vld <= 1'b0;
        end else if (w_en) begin
            r_e_side.vld <= r_d_side.vld;
        end
        if (w_en) begin
            r_e_side.tick <= r_d_side.tick;
            r_e_side.zero <= r_d_side.zero;
            r_e_side.lvl  <= r_d_side.lvl;
            for (int c = 0; c < 2; c++) begin
                r_e_v[c] <= w_tone[c];
            end
        end
    end

    // Stage F: scale to bytes, choose green, and hold the result beat.
    logic [23:0] w_sc [2];
    logic [7:0]  w_byte [2];
    t_pix_out    w_out;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_sc[c]   = {r_e_v[c], 8'd0} - {8'd0, r_e_v[c]} + 24'd255;
            w_byte[c] = w_sc[c][23:16];
        end
        w_out.fade_level = r_e_side.lvl;
        if (r_e_side.tick) begin
            w_out.out_red   = 8'd0;
            w_out.out_green = 8'd0;
            w_out.out_blue  = 8'd0;
        end else begin
            w_out.out_red   = w_byte[0];
            w_out.out_blue  = w_byte[1];
            w_out.out_green = r_e_side.lvl[1] ? w_byte[0] : w_byte[1];
        end
    end

    logic     r_f_vld;
    t_pix_out r_f_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_e_side.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_out <= w_out;
        end
    end

    assign o_res_valid = r_f_vld;
    assign o_res       = r_f_out;

    // A stalled pipeline keeps an occupied stage C occupied.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_side.vld && !w_en) |=> r_c_side.vld)
        else $error("pipeline stage lost a beat during a stall");

    // The low tone level never exceeds the high one.
    a_p_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_side.vld |-> (r_d_p <= r_d_q))
        else $error("p exceeds q in the back conversion");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

endmodule
